### rtl/gzc_pkg.sv
// Shared types, codes and constants of the gzip container checker.
`default_nettype none
package gzc_pkg;

	localparam int unsigned CFG_ADDR_W      = 3;
	localparam int unsigned CFG_DATA_W      = 32;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam logic [1:0] KIND_CONT   = 2'd0;
	localparam logic [1:0] KIND_DATA   = 2'd1;
	localparam logic [1:0] KIND_FINISH = 2'd2;

	localparam logic [1:0] CLS_HEADER  = 2'd0;
	localparam logic [1:0] CLS_PAYLOAD = 2'd1;
	localparam logic [1:0] CLS_TRAILER = 2'd2;
	localparam logic [1:0] CLS_NONE    = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DATA_ERR = 2'd1;
	localparam logic [1:0] ST_BUF_ERR  = 2'd2;

	localparam logic [7:0]  GZ_ID1        = 8'h1F;
	localparam logic [7:0]  GZ_ID2        = 8'h8B;
	localparam logic [7:0]  GZ_CM_DEFLATE = 8'd8;
	localparam logic [7:0]  FLG_RSVD_MASK = 8'hE0;
	localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT      = 32'hFFFFFFFF;
	localparam logic [31:0] HCRC_MASK     = 32'h0000FFFF;
	localparam logic [31:0] MIN_GZ_LEN    = 32'd18;
	localparam logic [31:0] XLEN_BASE     = 32'd12;
	localparam logic [31:0] TRAILER_LEN   = 32'd8;
	localparam logic [31:0] FIXED_LAST    = 32'd9;

	localparam int unsigned FLG_FHCRC    = 1;
	localparam int unsigned FLG_FEXTRA   = 2;
	localparam int unsigned FLG_FNAME    = 3;
	localparam int unsigned FLG_FCOMMENT = 4;

	typedef enum logic [1:0] {
		OP_CONT,
		OP_DATA,
		OP_FINISH,
		OP_NONE
	} op_t;

	typedef enum logic [3:0] {
		PH_FIXED,
		PH_XLEN_LO,
		PH_XLEN_HI,
		PH_EXTRA,
		PH_NAME,
		PH_COMMENT,
		PH_HCRC_LO,
		PH_HCRC_HI,
		PH_BODY,
		PH_DEAD
	} phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic       inflate_ok;
	} in_item_t;

	typedef struct packed {
		logic [1:0] byte_class;
		logic [7:0] out_byte;
		logic       payload_last;
		logic       done_res;
		logic [1:0] status;
	} out_item_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data_byte;
		logic       inflate_ok;
	} front_item_t;

endpackage
`default_nettype wire

### rtl/gzip_container_checker.sv
// Top level of the gzip container checker: configuration registers, front and back ends.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+------------------------------
//  items     | push / full                  | item   (kind, data_byte, inflate_ok)
//  results   | empty / pop                  | result (byte_class .. status)
//  config    | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// One item per cycle unless results back up; the back end updates all stream state per item.
// Items pass the item queue; their results pass the result queue to the result ports.
// Reset clears the registers and all stream state at once; no clearing pass.
// With pop low the result queue fills, then the item queue, then full rises.
`default_nettype none
module gzip_container_checker #(
	parameter int unsigned QUEUE_DEPTH = gzc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [gzc_pkg::CFG_ADDR_W-1:0]    paddr,
	input  wire  [gzc_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [gzc_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                              pready,
	input  wire                               push,
	output logic                              full,
	input  gzc_pkg::in_item_t                 item,
	output logic                              empty,
	input  wire                               pop,
	output gzc_pkg::out_item_t                result
);

	import gzc_pkg::*;

	logic [31:0] container_length_q;
	logic [31:0] output_capacity_q;
	logic        cfg_wr;
	front_item_t head;
	logic        head_valid;
	logic        take;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = paddr[2] ? output_capacity_q : container_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			container_length_q <= '0;
			output_capacity_q  <= '0;
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				output_capacity_q <= pwdata;
			end else begin
				container_length_q <= pwdata;
			end
		end
	end

	gzc_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.item       (item),
		.full       (full),
		.take       (take),
		.head       (head),
		.head_valid (head_valid)
	);

	gzc_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.container_length (container_length_q),
		.output_capacity  (output_capacity_q),
		.head             (head),
		.head_valid       (head_valid),
		.take             (take),
		.empty            (empty),
		.pop              (pop),
		.result           (result)
	);

endmodule
`default_nettype wire

### rtl/gzc_fifo.sv
// Small register queue used between the stages of the checker.
`default_nettype none
module gzc_fifo #(
	parameter type         item_t = logic [7:0],
	parameter int unsigned DEPTH  = 2
) (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   wr_en,
	input  item_t wr_item,
	output logic  full,
	input  wire   rd_en,
	output item_t rd_item,
	output logic  empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count missed a write");
	a_cnt_down: assert property (@(posedge clk) disable iff (!arst_n)
		(do_rd && !do_wr) |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue count missed a read");
`endif

endmodule
`default_nettype wire

### rtl/gzc_front.sv
// Front end: decode the item kind and hold items for the back end.
`default_nettype none
module gzc_front #(
	parameter int unsigned QUEUE_DEPTH = gzc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  gzc_pkg::in_item_t   item,
	output logic                full,
	input  wire                 take,
	output gzc_pkg::front_item_t head,
	output logic                head_valid
);

	import gzc_pkg::*;

	front_item_t dec_item;
	logic        q_empty;

	always_comb begin
		dec_item.data_byte  = item.data_byte;
		dec_item.inflate_ok = item.inflate_ok;
		case (item.kind)
			KIND_CONT:   dec_item.op = OP_CONT;
			KIND_DATA:   dec_item.op = OP_DATA;
			KIND_FINISH: dec_item.op = OP_FINISH;
			default:     dec_item.op = OP_NONE;
		endcase
	end

	gzc_fifo #(
		.item_t (front_item_t),
		.DEPTH  (QUEUE_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_item (dec_item),
		.full    (full),
		.rd_en   (take),
		.rd_item (head),
		.empty   (q_empty)
	);

	assign head_valid = ~q_empty;

endmodule
`default_nettype wire

### rtl/gzc_back.sv
// Back end: header parser, trailer capture, data CRC and verdict, with result queue.
`default_nettype none
module gzc_back #(
	parameter int unsigned QUEUE_DEPTH = gzc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire  [31:0]          container_length,
	input  wire  [31:0]          output_capacity,
	input  gzc_pkg::front_item_t head,
	input  wire                  head_valid,
	output logic                 take,
	output logic                 empty,
	input  wire                  pop,
	output gzc_pkg::out_item_t   result
);

	import gzc_pkg::*;

	phase_t      phase_q, phase_d;
	logic [31:0] cnt_q, cnt_d;
	logic [4:0]  flags_q, flags_d;
	logic [15:0] extra_q, extra_d;
	logic [31:0] hcrc_q, hcrc_d;
	logic [15:0] shcrc_q, shcrc_d;
	logic [31:0] hend_q, hend_d;
	logic [31:0] tcrc_q, tcrc_d;
	logic [31:0] tsize_q, tsize_d;
	logic [31:0] dcrc_q, dcrc_d;
	logic [31:0] dcount_q, dcount_d;
	logic        herr_q, herr_d;

	logic        oq_full;
	out_item_t   res;
	logic        in_range;
	logic        in_trailer;
	logic        is_last;
	logic [2:0]  toff;
	logic [15:0] xlen;
	logic [15:0] hcrc_rx;
	logic        go_next;
	logic        do_fail;
	phase_t      sect_after;
	phase_t      sect_next;
	logic [1:0]  fin_status;
	logic [7:0]  b;

	function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] d);
		logic [31:0] r;
		r = c ^ {24'd0, d};
		for (int i = 0; i < 8; i++) begin
			r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
		end
		return r;
	endfunction

	function automatic phase_t next_section(input phase_t after, input logic [4:0] flg);
		phase_t p;
		if (after < PH_XLEN_LO && flg[FLG_FEXTRA]) begin
			p = PH_XLEN_LO;
		end else if (after < PH_NAME && flg[FLG_FNAME]) begin
			p = PH_NAME;
		end else if (after < PH_COMMENT && flg[FLG_FCOMMENT]) begin
			p = PH_COMMENT;
		end else if (after < PH_HCRC_LO && flg[FLG_FHCRC]) begin
			p = PH_HCRC_LO;
		end else begin
			p = PH_BODY;
		end
		return p;
	endfunction

	assign take       = head_valid & ~oq_full;
	assign b          = head.data_byte;
	assign in_range   = cnt_q < container_length;
	assign in_trailer = ({1'b0, cnt_q} + {1'b0, TRAILER_LEN}) >= {1'b0, container_length};
	assign is_last    = ({1'b0, cnt_q} + 33'd9) == {1'b0, container_length};
	assign toff       = cnt_q[2:0] - container_length[2:0];
	assign xlen       = {b, extra_q[7:0]};
	assign hcrc_rx    = {b, shcrc_q[7:0]};
	assign sect_next  = next_section(sect_after, flags_q);

	always_comb begin
		if (herr_q || container_length < MIN_GZ_LEN || phase_q != PH_BODY) begin
			fin_status = ST_DATA_ERR;
		end else if (tsize_q > output_capacity) begin
			fin_status = ST_BUF_ERR;
		end else if (({1'b0, hend_q} + {1'b0, TRAILER_LEN}) > {1'b0, container_length}) begin
			fin_status = ST_DATA_ERR;
		end else if (!head.inflate_ok) begin
			fin_status = ST_DATA_ERR;
		end else if (dcount_q != tsize_q) begin
			fin_status = ST_DATA_ERR;
		end else if ((dcrc_q ^ CRC_INIT) != tcrc_q) begin
			fin_status = ST_DATA_ERR;
		end else begin
			fin_status = ST_OK;
		end
	end

	// header parser control: which section follows, and whether the header failed
	always_comb begin
		go_next    = 1'b0;
		do_fail    = 1'b0;
		sect_after = phase_q;
		case (phase_q)
			PH_FIXED: begin
				if ((cnt_q == 32'd0 && b != GZ_ID1) || (cnt_q == 32'd1 && b != GZ_ID2) ||
					(cnt_q == 32'd2 && b != GZ_CM_DEFLATE) ||
					(cnt_q == 32'd3 && (b & FLG_RSVD_MASK) != 8'd0)) begin
					do_fail = 1'b1;
				end else if (cnt_q == FIXED_LAST) begin
					go_next = 1'b1;
				end
			end
			PH_XLEN_HI: begin
				if (container_length < XLEN_BASE ||
					{16'd0, xlen} > container_length - XLEN_BASE) begin
					do_fail = 1'b1;
				end else if (xlen == 16'd0) begin
					go_next    = 1'b1;
					sect_after = PH_EXTRA;
				end
			end
			PH_EXTRA: begin
				go_next = (extra_q - 16'd1) == 16'd0;
			end
			PH_NAME, PH_COMMENT: begin
				go_next = (b == 8'd0);
			end
			PH_HCRC_HI: begin
				if ({16'd0, hcrc_rx} != ((hcrc_q ^ CRC_INIT) & HCRC_MASK)) begin
					do_fail = 1'b1;
				end else begin
					go_next = 1'b1;
				end
			end
			default: begin
				go_next = 1'b0;
			end
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		flags_d  = flags_q;
		extra_d  = extra_q;
		hcrc_d   = hcrc_q;
		shcrc_d  = shcrc_q;
		hend_d   = hend_q;
		tcrc_d   = tcrc_q;
		tsize_d  = tsize_q;
		dcrc_d   = dcrc_q;
		dcount_d = dcount_q;
		herr_d   = herr_q;
		if (take) begin
			case (head.op)
				OP_CONT: begin
					if (in_range) begin
						if (in_trailer) begin
							if (!toff[2]) begin
								tcrc_d[{toff[1:0], 3'b000} +: 8] =
									tcrc_q[{toff[1:0], 3'b000} +: 8] | b;
							end else begin
								tsize_d[{toff[1:0], 3'b000} +: 8] =
									tsize_q[{toff[1:0], 3'b000} +: 8] | b;
							end
						end
						if (phase_q != PH_BODY) begin
							if (phase_q < PH_HCRC_LO) begin
								hcrc_d = crc_step(hcrc_q, b);
							end
							case (phase_q)
								PH_FIXED: begin
									if (cnt_q == 32'd3) begin
										flags_d = b[4:0];
									end
								end
								PH_XLEN_LO: begin
									extra_d = {8'd0, b};
									phase_d = PH_XLEN_HI;
								end
								PH_XLEN_HI: begin
									extra_d = xlen;
									phase_d = PH_EXTRA;
								end
								PH_EXTRA: begin
									extra_d = extra_q - 16'd1;
								end
								PH_HCRC_LO: begin
									shcrc_d = {8'd0, b};
									phase_d = PH_HCRC_HI;
								end
								PH_HCRC_HI: begin
									shcrc_d = hcrc_rx;
								end
								default: begin
									phase_d = phase_q;
								end
							endcase
							if (do_fail) begin
								herr_d  = 1'b1;
								phase_d = PH_DEAD;
							end else if (go_next) begin
								phase_d = sect_next;
								if (sect_next == PH_BODY) begin
									hend_d = cnt_q + 32'd1;
								end
							end
						end
						cnt_d = cnt_q + 32'd1;
					end
				end
				OP_DATA: begin
					dcrc_d = crc_step(dcrc_q, b);
					if (dcount_q != 32'hFFFFFFFF) begin
						dcount_d = dcount_q + 32'd1;
					end
				end
				OP_FINISH: begin
					phase_d  = PH_FIXED;
					cnt_d    = '0;
					flags_d  = '0;
					extra_d  = '0;
					hcrc_d   = CRC_INIT;
					shcrc_d  = '0;
					hend_d   = '0;
					tcrc_d   = '0;
					tsize_d  = '0;
					dcrc_d   = CRC_INIT;
					dcount_d = '0;
					herr_d   = 1'b0;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	always_comb begin
		res              = '0;
		res.byte_class   = CLS_NONE;
		res.status       = herr_d ? ST_DATA_ERR : ST_OK;
		case (head.op)
			OP_CONT: begin
				if (in_range) begin
					if (phase_q != PH_BODY) begin
						res.byte_class = CLS_HEADER;
					end else if (in_trailer) begin
						res.byte_class = CLS_TRAILER;
					end else begin
						res.byte_class   = CLS_PAYLOAD;
						res.out_byte     = b;
						res.payload_last = is_last;
					end
				end
			end
			OP_FINISH: begin
				res.done_res = 1'b1;
				res.status   = fin_status;
			end
			default: begin
				res.byte_class = CLS_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FIXED;
			cnt_q    <= '0;
			flags_q  <= '0;
			extra_q  <= '0;
			hcrc_q   <= CRC_INIT;
			shcrc_q  <= '0;
			hend_q   <= '0;
			tcrc_q   <= '0;
			tsize_q  <= '0;
			dcrc_q   <= CRC_INIT;
			dcount_q <= '0;
			herr_q   <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			flags_q  <= flags_d;
			extra_q  <= extra_d;
			hcrc_q   <= hcrc_d;
			shcrc_q  <= shcrc_d;
			hend_q   <= hend_d;
			tcrc_q   <= tcrc_d;
			tsize_q  <= tsize_d;
			dcrc_q   <= dcrc_d;
			dcount_q <= dcount_d;
			herr_q   <= herr_d;
		end
	end

	gzc_fifo #(
		.item_t (out_item_t),
		.DEPTH  (QUEUE_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (take),
		.wr_item (res),
		.full    (oq_full),
		.rd_en   (pop),
		.rd_item (result),
		.empty   (empty)
	);

`ifndef SYNTHESIS
	a_err_dead: assert property (@(posedge clk) disable iff (!arst_n)
		herr_q |-> phase_q == PH_DEAD)
		else $error("header error without parser stop");
	a_body_end: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> hend_q != '0)
		else $error("body phase without header end");
	a_finish_clr: assert property (@(posedge clk) disable iff (!arst_n)
		(take && head.op == OP_FINISH) |=> (cnt_q == '0 && phase_q == PH_FIXED && !herr_q))
		else $error("stream state not cleared after finish");
	a_data_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(take && head.op == OP_DATA) |=> dcount_q != '0)
		else $error("decompressed count did not advance");
`endif

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for gzip_container_checker: gzip member streams against a predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gzc_pkg::*;

	localparam int unsigned ITEM_TARGET          = 1150;
	localparam int unsigned REG_CONTAINER_LENGTH = 0;
	localparam int unsigned REG_OUTPUT_CAPACITY  = 1;

	typedef enum {
		FLT_NONE,
		FLT_HEADER,
		FLT_XLEN,
		FLT_CRC,
		FLT_SIZE,
		FLT_INFLATE,
		FLT_CAPACITY,
		FLT_SHORT,
		FLT_LONG,
		FLT_NOISE
	} fault_t;

	logic                  clk     = 1'b0;
	logic                  arst_n  = 1'b0;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr   = '0;
	logic [CFG_DATA_W-1:0] pwdata  = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  push    = 1'b0;
	logic                  full;
	in_item_t              item    = '0;
	logic                  empty;
	logic                  pop     = 1'b0;
	out_item_t             result;

	int unsigned send_idle_pct = 14;
	int unsigned recv_idle_pct = 58;
	int unsigned items_sent    = 0;
	int unsigned members_run   = 0;

	function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
		c = c ^ {24'h0, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
		end
		return c;
	endfunction

	class container_predictor;
		logic [31:0] cfg_length;
		logic [31:0] cfg_capacity;
		phase_t      phase;
		logic [31:0] byte_pos;
		logic [4:0]  flags;
		logic [15:0] extra_left;
		logic [31:0] hdr_crc;
		logic [15:0] hdr_crc_rx;
		logic [31:0] hdr_end;
		logic [31:0] trl_crc;
		logic [31:0] trl_size;
		logic [31:0] dat_crc;
		logic [31:0] dat_count;
		bit          hdr_err;
		out_item_t   predicted[$];
		int unsigned failures;
		int unsigned checked;
		int unsigned verdicts[3];

		function new();
			cfg_length   = '0;
			cfg_capacity = '0;
			failures     = 0;
			checked      = 0;
			verdicts     = '{0, 0, 0};
			clear_stream();
		endfunction

		function void clear_stream();
			phase      = PH_FIXED;
			byte_pos   = '0;
			flags      = '0;
			extra_left = '0;
			hdr_crc    = CRC_INIT;
			hdr_crc_rx = '0;
			hdr_end    = '0;
			trl_crc    = '0;
			trl_size   = '0;
			dat_crc    = CRC_INIT;
			dat_count  = '0;
			hdr_err    = 1'b0;
		endfunction

		function void fail_hdr();
			hdr_err = 1'b1;
			phase   = PH_DEAD;
		endfunction

		function void advance_section(phase_t after);
			if (after < PH_XLEN_LO && flags[FLG_FEXTRA]) begin
				phase = PH_XLEN_LO;
			end else if (after < PH_NAME && flags[FLG_FNAME]) begin
				phase = PH_NAME;
			end else if (after < PH_COMMENT && flags[FLG_FCOMMENT]) begin
				phase = PH_COMMENT;
			end else if (after < PH_HCRC_LO && flags[FLG_FHCRC]) begin
				phase = PH_HCRC_LO;
			end else begin
				phase   = PH_BODY;
				hdr_end = byte_pos + 32'd1;
			end
		endfunction

		function void note_item(in_item_t it);
			out_item_t  r;
			logic [7:0] b;
			logic [2:0] off;
			bit         tail;
			b = it.data_byte;
			r = '{byte_class: CLS_NONE, out_byte: 8'h00, payload_last: 1'b0,
				done_res: 1'b0, status: ST_OK};
			case (op_t'(it.kind))
				OP_CONT: begin
					if (byte_pos < cfg_length) begin
						tail = ({1'b0, byte_pos} + {1'b0, TRAILER_LEN}) >= {1'b0, cfg_length};
						if (tail) begin
							off = byte_pos[2:0] - cfg_length[2:0];
							if (off < 4) trl_crc = trl_crc | ({24'h0, b} << (8 * off));
							else trl_size = trl_size | ({24'h0, b} << (8 * (off - 4)));
						end
						if (phase != PH_BODY) begin
							r.byte_class = CLS_HEADER;
							if (phase < PH_HCRC_LO) hdr_crc = crc32_step(hdr_crc, b);
							case (phase)
								PH_FIXED: begin
									if ((byte_pos == 0 && b != GZ_ID1) ||
										(byte_pos == 1 && b != GZ_ID2) ||
										(byte_pos == 2 && b != GZ_CM_DEFLATE) ||
										(byte_pos == 3 && (b & FLG_RSVD_MASK) != 8'h00)) begin
										fail_hdr();
									end else begin
										if (byte_pos == 3) flags = b[4:0];
										if (byte_pos == FIXED_LAST) advance_section(PH_FIXED);
									end
								end
								PH_XLEN_LO: begin
									extra_left = {8'h00, b};
									phase      = PH_XLEN_HI;
								end
								PH_XLEN_HI: begin
									extra_left[15:8] = b;
									if (cfg_length < XLEN_BASE ||
										{16'h0, extra_left} > cfg_length - XLEN_BASE) begin
										fail_hdr();
									end else if (extra_left == 16'h0) begin
										advance_section(PH_EXTRA);
									end else begin
										phase = PH_EXTRA;
									end
								end
								PH_EXTRA: begin
									extra_left = extra_left - 16'd1;
									if (extra_left == 16'h0) advance_section(PH_EXTRA);
								end
								PH_NAME, PH_COMMENT: begin
									if (b == 8'h00) advance_section(phase);
								end
								PH_HCRC_LO: begin
									hdr_crc_rx = {8'h00, b};
									phase      = PH_HCRC_HI;
								end
								PH_HCRC_HI: begin
									hdr_crc_rx[15:8] = b;
									if ({16'h0, hdr_crc_rx} != ((hdr_crc ^ CRC_INIT) & HCRC_MASK))
										fail_hdr();
									else
										advance_section(PH_HCRC_HI);
								end
								default: ;
							endcase
						end else if (tail) begin
							r.byte_class = CLS_TRAILER;
						end else begin
							r.byte_class   = CLS_PAYLOAD;
							r.out_byte     = b;
							r.payload_last = ({1'b0, byte_pos} + {1'b0, TRAILER_LEN} + 33'd1)
								== {1'b0, cfg_length};
						end
						byte_pos = byte_pos + 32'd1;
					end
				end
				OP_DATA: begin
					dat_crc = crc32_step(dat_crc, b);
					if (dat_count != 32'hFFFF_FFFF) dat_count = dat_count + 32'd1;
				end
				OP_FINISH: begin
					r.done_res = 1'b1;
					if (hdr_err || cfg_length < MIN_GZ_LEN || phase != PH_BODY)
						r.status = ST_DATA_ERR;
					else if (trl_size > cfg_capacity)
						r.status = ST_BUF_ERR;
					else if (({1'b0, hdr_end} + {1'b0, TRAILER_LEN}) > {1'b0, cfg_length} ||
						!it.inflate_ok || dat_count != trl_size || (dat_crc ^ CRC_INIT) != trl_crc)
						r.status = ST_DATA_ERR;
					else
						r.status = ST_OK;
					verdicts[r.status]++;
					clear_stream();
				end
				default: ;
			endcase
			if (!r.done_res && hdr_err) r.status = ST_DATA_ERR;
			predicted.push_back(r);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (predicted.size() == 0) begin
				$error("result with nothing pending: %p", got);
				failures++;
				return;
			end
			want = predicted.pop_front();
			checked++;
			if (got.byte_class !== want.byte_class) begin
				$error("byte_class expected %0d actual %0d", want.byte_class, got.byte_class);
				failures++;
			end
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte expected %02h actual %02h", want.out_byte, got.out_byte);
				failures++;
			end
			if (got.payload_last !== want.payload_last) begin
				$error("payload_last expected %0b actual %0b", want.payload_last, got.payload_last);
				failures++;
			end
			if (got.done_res !== want.done_res) begin
				$error("done_res expected %0b actual %0b", want.done_res, got.done_res);
				failures++;
			end
			if (got.status !== want.status) begin
				$error("status expected %0d actual %0d", want.status, got.status);
				failures++;
			end
		endfunction
	endclass

	container_predictor board;

	gzip_container_checker u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) board.check_result(result);
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_item(in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		board.note_item(it);
		if (it.kind != OP_NONE) items_sent++;
	endtask

	task automatic write_reg(int unsigned idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_W'(4 * idx);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_CONTAINER_LENGTH) board.cfg_length = value;
		else board.cfg_capacity = value;
		@(posedge clk);
	endtask

	task automatic settle();
		push <= 1'b0;
		while (board.predicted.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_member(fault_t fault);
		logic [7:0]  cont[$];
		logic [7:0]  plain[$];
		logic [4:0]  flg;
		logic [15:0] xlen;
		logic [31:0] crc;
		logic [31:0] isize;
		logic [31:0] len;
		logic [31:0] cap;
		int unsigned hlen;
		int unsigned n;
		int unsigned ci;
		int unsigned pi;
		in_item_t    it;
		if (fault == FLT_NOISE) begin
			settle();
			write_reg(REG_CONTAINER_LENGTH, $urandom_range(0, 40));
			repeat ($urandom_range(5, 40))
				send_item('{2'($urandom()), 8'($urandom()), 1'($urandom())});
			send_item('{OP_FINISH, 8'($urandom()), 1'($urandom())});
			return;
		end
		flg  = 5'($urandom());
		xlen = 16'($urandom_range(0, 6));
		if (fault == FLT_XLEN) flg[FLG_FEXTRA] = 1'b1;
		cont = '{GZ_ID1, GZ_ID2, GZ_CM_DEFLATE, {3'b000, flg}};
		repeat (6) cont.push_back(8'($urandom()));
		if (flg[FLG_FEXTRA]) begin
			cont.push_back(xlen[7:0]);
			cont.push_back(fault == FLT_XLEN ? 8'hFF : xlen[15:8]);
			repeat (xlen) cont.push_back(8'($urandom()));
		end
		if (flg[FLG_FNAME]) begin
			repeat ($urandom_range(0, 5)) cont.push_back(8'($urandom_range(1, 255)));
			cont.push_back(8'h00);
		end
		if (flg[FLG_FCOMMENT]) begin
			repeat ($urandom_range(0, 5)) cont.push_back(8'($urandom_range(1, 255)));
			cont.push_back(8'h00);
		end
		if (flg[FLG_FHCRC]) begin
			crc = CRC_INIT;
			foreach (cont[i]) crc = crc32_step(crc, cont[i]);
			crc = crc ^ CRC_INIT;
			cont.push_back(crc[7:0]);
			cont.push_back(crc[15:8]);
		end
		hlen = cont.size();
		if (fault == FLT_HEADER) begin
			n = $urandom_range(0, 4);
			if (n == 4) n = $urandom_range(4, hlen - 1);
			cont[n] = cont[n] ^ (8'h01 << (n == 3 ? $urandom_range(5, 7) : $urandom_range(0, 7)));
		end
		repeat ($urandom_range(0, 12)) cont.push_back(8'($urandom()));
		repeat ($urandom_range(0, 12)) plain.push_back(8'($urandom()));
		crc = CRC_INIT;
		foreach (plain[i]) crc = crc32_step(crc, plain[i]);
		crc = crc ^ CRC_INIT;
		if (fault == FLT_CRC) crc = crc ^ (32'h1 << $urandom_range(0, 31));
		isize = plain.size();
		for (int k = 0; k < 4; k++) cont.push_back(crc[8 * k +: 8]);
		for (int k = 0; k < 4; k++) cont.push_back(isize[8 * k +: 8]);
		if (fault == FLT_SIZE) begin
			if (plain.size() != 0 && $urandom_range(0, 1)) void'(plain.pop_back());
			else plain.push_back(8'($urandom()));
		end
		len = cont.size();
		if (fault == FLT_SHORT) len = $urandom_range(hlen - 3, hlen + 7);
		if (fault == FLT_LONG) len = len + $urandom_range(1, 16);
		case ($urandom_range(0, 3))
			0: cap = isize;
			1: cap = 32'hFFFF_FFFF;
			2: cap = isize + $urandom_range(1, 1000);
			default: cap = $urandom();
		endcase
		if (fault == FLT_CAPACITY) cap = (isize == 0) ? 32'h0 : isize - 32'd1;
		settle();
		write_reg(REG_CONTAINER_LENGTH, len);
		if (fault == FLT_CAPACITY || $urandom_range(0, 3) != 0) write_reg(REG_OUTPUT_CAPACITY, cap);
		ci = 0;
		pi = 0;
		while (ci < cont.size() || pi < plain.size()) begin
			if (pi < plain.size() && (ci >= cont.size() || $urandom_range(0, 3) == 0)) begin
				it = '{OP_DATA, plain[pi], 1'($urandom())};
				pi++;
			end else begin
				it = '{OP_CONT, cont[ci], 1'($urandom())};
				ci++;
			end
			send_item(it);
			if ($urandom_range(0, 49) == 0)
				send_item('{OP_NONE, 8'($urandom()), 1'($urandom())});
		end
		send_item('{OP_FINISH, 8'($urandom()), fault != FLT_INFLATE});
	endtask

	initial begin
		logic [7:0] xlen_hdr[$];
		logic [7:0] rsvd_hdr[$];
		int unsigned r;
		board    = new();
		xlen_hdr = '{GZ_ID1, GZ_ID2, GZ_CM_DEFLATE, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'hFF, 8'h01, 8'h00};
		rsvd_hdr = '{GZ_ID1, GZ_ID2, GZ_CM_DEFLATE, 8'h20, 8'hFF};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_CONTAINER_LENGTH, 32'h0);
		write_reg(REG_OUTPUT_CAPACITY, 32'h0);
		send_item('{OP_CONT, 8'hFF, 1'b1});
		send_item('{OP_NONE, 8'h00, 1'b1});
		send_item('{OP_DATA, 8'hFF, 1'b0});
		send_item('{OP_DATA, 8'h00, 1'b1});
		send_item('{OP_FINISH, 8'h00, 1'b0});
		settle();
		write_reg(REG_CONTAINER_LENGTH, 32'd12);
		write_reg(REG_OUTPUT_CAPACITY, 32'hFFFF_FFFF);
		foreach (xlen_hdr[i]) send_item('{OP_CONT, xlen_hdr[i], 1'b0});
		send_item('{OP_FINISH, 8'hFF, 1'b1});
		settle();
		write_reg(REG_CONTAINER_LENGTH, 32'hFFFF_FFFF);
		foreach (rsvd_hdr[i]) send_item('{OP_CONT, rsvd_hdr[i], 1'b1});
		send_item('{OP_FINISH, 8'h00, 1'b1});

		while (items_sent < ITEM_TARGET) begin
			if (items_sent < ITEM_TARGET / 3) begin
				send_idle_pct = 14;
				recv_idle_pct = 58;
			end else if (items_sent < 2 * ITEM_TARGET / 3) begin
				send_idle_pct = 58;
				recv_idle_pct = 14;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			r = $urandom_range(0, 13);
			run_member(r < 5 ? FLT_NONE : fault_t'(r - 4));
			members_run++;
		end
		settle();

		$display("Transferred %0d items in %0d gzip members; %0d results checked.",
			items_sent, members_run, board.checked);
		$display("Verdicts seen: %0d ok, %0d data error, %0d buffer error.",
			board.verdicts[ST_OK], board.verdicts[ST_DATA_ERR], board.verdicts[ST_BUF_ERR]);
		if (board.failures == 0 && board.predicted.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
